[rtl/pirt_pkg.sv]
package pirt_pkg;

    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_X_FIRST  = 3'd0;
    localparam t_reg_idx REG_X_SECOND = 3'd1;
    localparam t_reg_idx REG_Y_FIRST  = 3'd2;
    localparam t_reg_idx REG_Y_SECOND = 3'd3;
    localparam t_reg_idx REG_SHAPE    = 3'd4;

    typedef enum logic [1:0] {
        SHAPE_RECT    = 2'd0,
        SHAPE_ELLIPSE = 2'd1,
        SHAPE_DIAMOND = 2'd2,
        SHAPE_LINE    = 2'd3
    } t_shape;

    typedef struct packed {
        logic   valid;
        logic   inbox;
        t_shape shape;
    } t_ctl;

endpackage

[rtl/pirt_point_if.sv]
interface pirt_point_if #(parameter int COORD_BITS = 24) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

[rtl/pirt_result_if.sv]
interface pirt_result_if ();
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, output inside_res, input ready);
    modport sink   (input valid, input inside_res, output ready);
endinterface

[rtl/pirt_cfg.sv]
module pirt_cfg import pirt_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_BITS-1:0]     paddr,
    input  logic [CFG_DATA_BITS-1:0]     pwdata,
    output logic [CFG_DATA_BITS-1:0]     prdata,
    output logic                         pready,
    output logic signed [COORD_BITS-1:0] o_x_first,
    output logic signed [COORD_BITS-1:0] o_x_second,
    output logic signed [COORD_BITS-1:0] o_y_first,
    output logic signed [COORD_BITS-1:0] o_y_second,
    output t_shape                       o_shape
);

    logic signed [COORD_BITS-1:0] r_x_first;
    logic signed [COORD_BITS-1:0] r_x_second;
    logic signed [COORD_BITS-1:0] r_y_first;
    logic signed [COORD_BITS-1:0] r_y_second;
    t_shape                       r_shape;
    t_reg_idx                     idx;
    logic                         wr;

    assign idx    = paddr[CFG_ADDR_BITS-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_first  <= '0;
            r_x_second <= '0;
            r_y_first  <= '0;
            r_y_second <= '0;
            r_shape    <= SHAPE_RECT;
        end else if (wr) begin
            unique case (idx)
                REG_X_FIRST:  r_x_first  <= pwdata[COORD_BITS-1:0];
                REG_X_SECOND: r_x_second <= pwdata[COORD_BITS-1:0];
                REG_Y_FIRST:  r_y_first  <= pwdata[COORD_BITS-1:0];
                REG_Y_SECOND: r_y_second <= pwdata[COORD_BITS-1:0];
                REG_SHAPE:    r_shape    <= t_shape'(pwdata[1:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_X_FIRST:  prdata = CFG_DATA_BITS'(r_x_first);
            REG_X_SECOND: prdata = CFG_DATA_BITS'(r_x_second);
            REG_Y_FIRST:  prdata = CFG_DATA_BITS'(r_y_first);
            REG_Y_SECOND: prdata = CFG_DATA_BITS'(r_y_second);
            REG_SHAPE:    prdata = CFG_DATA_BITS'(r_shape);
            default:      prdata = '0;
        endcase
    end

    assign o_x_first  = r_x_first;
    assign o_x_second = r_x_second;
    assign o_y_first  = r_y_first;
    assign o_y_second = r_y_second;
    assign o_shape    = r_shape;

endmodule

[rtl/pirt_front.sv]
module pirt_front import pirt_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_x_first,
    input  logic signed [COORD_BITS-1:0] i_x_second,
    input  logic signed [COORD_BITS-1:0] i_y_first,
    input  logic signed [COORD_BITS-1:0] i_y_second,
    input  t_shape                       i_shape,
    output t_ctl                         o_ctl,
    output logic [COORD_BITS-1:0]        o_w,
    output logic [COORD_BITS-1:0]        o_h,
    output logic [COORD_BITS-1:0]        o_dx,
    output logic [COORD_BITS-1:0]        o_dy
);

    localparam int N  = COORD_BITS;
    localparam int XW = COORD_BITS + 2;

    logic signed [N-1:0]  left;
    logic signed [N-1:0]  top;
    logic signed [XW-1:0] left_x;
    logic signed [XW-1:0] right_x;
    logic signed [XW-1:0] top_x;
    logic signed [XW-1:0] bottom_x;
    logic signed [XW-1:0] px_x;
    logic signed [XW-1:0] py_x;
    logic signed [XW-1:0] w_x;
    logic signed [XW-1:0] h_x;
    logic signed [XW-1:0] dx_x;
    logic signed [XW-1:0] dy_x;
    logic signed [XW-1:0] dx_m;
    logic signed [XW-1:0] dy_m;
    logic                 nonempty;
    logic                 inbox;
    t_ctl                 r_ctl;
    logic [N-1:0]         r_w;
    logic [N-1:0]         r_h;
    logic [N-1:0]         r_dx;
    logic [N-1:0]         r_dy;

    assign left     = (i_x_first < i_x_second) ? i_x_first : i_x_second;
    assign top      = (i_y_first < i_y_second) ? i_y_first : i_y_second;
    assign left_x   = XW'(left);
    assign right_x  = XW'(i_x_second);
    assign top_x    = XW'(top);
    assign bottom_x = XW'(i_y_second);
    assign px_x     = XW'(i_px);
    assign py_x     = XW'(i_py);

    assign nonempty = (left < i_x_second) && (top < i_y_second);
    assign inbox    = nonempty && (i_px >= left) && (i_px <= i_x_second)
                      && (i_py >= top) && (i_py <= i_y_second);

    assign w_x  = right_x - left_x;
    assign h_x  = bottom_x - top_x;
    // twice the offset from the center; magnitude fits N bits when in the box
    assign dx_x = (px_x <<< 1) - left_x - right_x;
    assign dy_x = (py_x <<< 1) - top_x - bottom_x;
    assign dx_m = dx_x[XW-1] ? -dx_x : dx_x;
    assign dy_m = dy_x[XW-1] ? -dy_x : dy_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl.valid <= i_valid;
            r_ctl.inbox <= inbox;
            r_ctl.shape <= i_shape;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w  <= w_x[N-1:0];
            r_h  <= h_x[N-1:0];
            r_dx <= dx_m[N-1:0];
            r_dy <= dy_m[N-1:0];
        end
    end

    assign o_ctl = r_ctl;
    assign o_w   = r_w;
    assign o_h   = r_h;
    assign o_dx  = r_dx;
    assign o_dy  = r_dy;

endmodule

[rtl/pirt_back.sv]
module pirt_back import pirt_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_ctl                  i_ctl,
    input  logic [COORD_BITS-1:0] i_w,
    input  logic [COORD_BITS-1:0] i_h,
    input  logic [COORD_BITS-1:0] i_dx,
    input  logic [COORD_BITS-1:0] i_dy,
    output logic                  o_valid,
    output logic                  o_inside
);

    localparam int N = COORD_BITS;
    localparam int P = 2 * COORD_BITS;
    localparam int Q = 4 * COORD_BITS;

    // lane 0: dx*h, lane 1: dy*w, lane 2: w*h
    logic [N-1:0] mul_a [3];
    logic [N-1:0] mul_b [3];
    logic [P-1:0] n_prod [3];
    logic [P-1:0] r_prod [3];
    logic [P-1:0] n_hh [3];
    logic [P-1:0] n_hl [3];
    logic [P-1:0] n_ll [3];
    logic [P-1:0] r_hh [3];
    logic [P-1:0] r_hl [3];
    logic [P-1:0] r_ll [3];
    logic [Q-1:0] n_sq [3];
    logic [Q-1:0] r_sq [3];
    t_ctl         r_ctl2;
    t_ctl         r_ctl3;
    t_ctl         r_ctl4;
    logic         n_dia;
    logic         r_dia3;
    logic         r_dia4;
    logic         n_ell;
    logic         n_inside;
    logic         r_valid5;
    logic         r_inside5;

    assign mul_a[0] = i_dx;
    assign mul_b[0] = i_h;
    assign mul_a[1] = i_dy;
    assign mul_b[1] = i_w;
    assign mul_a[2] = i_w;
    assign mul_b[2] = i_h;

    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign n_prod[k] = mul_a[k] * mul_b[k];
        // square of the product, split into N-bit halves
        assign n_hh[k] = r_prod[k][P-1:N] * r_prod[k][P-1:N];
        assign n_hl[k] = r_prod[k][P-1:N] * r_prod[k][N-1:0];
        assign n_ll[k] = r_prod[k][N-1:0] * r_prod[k][N-1:0];
        assign n_sq[k] = (Q'(r_hh[k]) << P) + (Q'(r_hl[k]) << (N + 1)) + Q'(r_ll[k]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod[k] <= n_prod[k];
                r_hh[k]   <= n_hh[k];
                r_hl[k]   <= n_hl[k];
                r_ll[k]   <= n_ll[k];
                r_sq[k]   <= n_sq[k];
            end
        end
    end

    assign n_dia = ({1'b0, r_prod[0]} + {1'b0, r_prod[1]}) <= {1'b0, r_prod[2]};
    assign n_ell = ({1'b0, r_sq[0]} + {1'b0, r_sq[1]}) <= {1'b0, r_sq[2]};

    always_comb begin
        unique case (r_ctl4.shape)
            SHAPE_RECT:    n_inside = r_ctl4.inbox;
            SHAPE_ELLIPSE: n_inside = r_ctl4.inbox && n_ell;
            SHAPE_DIAMOND: n_inside = r_ctl4.inbox && r_dia4;
            SHAPE_LINE:    n_inside = 1'b0;
            default:       n_inside = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2   <= '0;
            r_ctl3   <= '0;
            r_ctl4   <= '0;
            r_valid5 <= 1'b0;
        end else if (i_en) begin
            r_ctl2   <= i_ctl;
            r_ctl3   <= r_ctl2;
            r_ctl4   <= r_ctl3;
            r_valid5 <= r_ctl4.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dia3    <= n_dia;
            r_dia4    <= r_dia3;
            r_inside5 <= n_inside;
        end
    end

    assign o_valid  = r_valid5;
    assign o_inside = r_inside5;

endmodule

[rtl/point_in_region_test.sv]
// Point-in-region test.
// i_pt carries one point (point_x, point_y, signed fixed point) per item;
// o_res returns one inside_res bit per item, in order. Both channels use
// valid/ready and move an item when both are high.
// The region (two x bounds, two y bounds, shape) sits in APB registers at
// byte addresses 0, 4, 8, 12 and 16; pready is tied high. Write them only
// while no item is in flight.
// Pipeline registers from input accept to result valid: box test, three
// products, half-width partial squares, full squares, final compare.
// Throughput: one item per cycle while no result waits on a low o_res.ready.
// When o_res.ready is low with a result waiting, the whole pipeline holds
// and i_pt.ready drops; nothing is lost or repeated.
// Synchronous active-low reset clears the registers to zero (rectangle) and
// empties the pipeline.
module point_in_region_test import pirt_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    pirt_point_if.sink               i_pt,
    pirt_result_if.source            o_res,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic signed [COORD_BITS-1:0] x_first;
    logic signed [COORD_BITS-1:0] x_second;
    logic signed [COORD_BITS-1:0] y_first;
    logic signed [COORD_BITS-1:0] y_second;
    t_shape                       shape;
    t_ctl                         ctl1;
    logic [COORD_BITS-1:0]        w1;
    logic [COORD_BITS-1:0]        h1;
    logic [COORD_BITS-1:0]        dx1;
    logic [COORD_BITS-1:0]        dy1;
    logic                         out_valid;
    logic                         out_inside;
    logic                         en;

    assign en          = !out_valid || o_res.ready;
    assign i_pt.ready  = en;
    assign o_res.valid = out_valid;
    assign o_res.inside_res = out_inside;

    pirt_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_x_first  (x_first),
        .o_x_second (x_second),
        .o_y_first  (y_first),
        .o_y_second (y_second),
        .o_shape    (shape)
    );

    pirt_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_pt.valid),
        .i_px       (i_pt.point_x),
        .i_py       (i_pt.point_y),
        .i_x_first  (x_first),
        .i_x_second (x_second),
        .i_y_first  (y_first),
        .i_y_second (y_second),
        .i_shape    (shape),
        .o_ctl      (ctl1),
        .o_w        (w1),
        .o_h        (h1),
        .o_dx       (dx1),
        .o_dy       (dy1)
    );

    pirt_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (ctl1),
        .i_w      (w1),
        .i_h      (h1),
        .i_dx     (dx1),
        .i_dy     (dy1),
        .o_valid  (out_valid),
        .o_inside (out_inside)
    );

`ifndef SYNTHESIS
    a_inside_not_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.inside_res |-> shape != SHAPE_LINE)
        else $error("inside reported for line shape");

    a_inside_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.inside_res |-> (x_first < x_second) && (y_first < y_second))
        else $error("inside reported for empty region");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |-> !i_pt.ready)
        else $error("input taken while result stalled");
`endif

endmodule
